>>> hw/rtl/field_invert_mod_p25519_core_macros.svh
// Assertion macros used by the checker file fimp_checker.sv
`ifndef FIELD_INVERT_MOD_P25519_CORE_MACROS_SVH
`define FIELD_INVERT_MOD_P25519_CORE_MACROS_SVH
`define FIMP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FIMP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/fimp_pkg.sv
package fimp_pkg;
    localparam int LimbW = 27;
    localparam int NLimb = 10;
    localparam int AccW  = 64;
    localparam int NOps  = 265;
    localparam int OpW   = 9;

    // operand sources and destinations of one chain step
    localparam logic [3:0] SRC_T    = 4'd0;
    localparam logic [3:0] SRC_Z    = 4'd1;
    localparam logic [3:0] SRC_Z2   = 4'd2;
    localparam logic [3:0] SRC_Z9   = 4'd3;
    localparam logic [3:0] SRC_Z11  = 4'd4;
    localparam logic [3:0] SRC_E5   = 4'd5;
    localparam logic [3:0] SRC_E10  = 4'd6;
    localparam logic [3:0] SRC_E20  = 4'd7;
    localparam logic [3:0] SRC_E50  = 4'd8;
    localparam logic [3:0] SRC_E100 = 4'd9;
    localparam logic [3:0] DST_T    = 4'd0;
    localparam logic [3:0] DST_Z2   = 4'd2;
    localparam logic [3:0] DST_Z9   = 4'd3;
    localparam logic [3:0] DST_Z11  = 4'd4;
    localparam logic [3:0] DST_E5   = 4'd5;
    localparam logic [3:0] DST_E10  = 4'd6;
    localparam logic [3:0] DST_E20  = 4'd7;
    localparam logic [3:0] DST_E50  = 4'd8;
    localparam logic [3:0] DST_E100 = 4'd9;

    typedef logic [LimbW-1:0] t_limb;
    typedef t_limb [NLimb-1:0] t_fe;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
    } t_op;

    function automatic t_op op_of(input logic [OpW-1:0] n);
        t_op o;
        int k;
        k = int'(n);
        if (k == 0) o = '{SRC_Z, SRC_Z, DST_Z2};
        else if (k == 1) o = '{SRC_Z2, SRC_Z2, DST_T};
        else if (k == 2) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 3) o = '{SRC_T, SRC_Z, DST_Z9};
        else if (k == 4) o = '{SRC_Z9, SRC_Z2, DST_Z11};
        else if (k == 5) o = '{SRC_Z11, SRC_Z11, DST_T};
        else if (k == 6) o = '{SRC_T, SRC_Z9, DST_E5};
        else if (k == 7) o = '{SRC_E5, SRC_E5, DST_T};
        else if (k <= 11) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 12) o = '{SRC_T, SRC_E5, DST_E10};
        else if (k == 13) o = '{SRC_E10, SRC_E10, DST_T};
        else if (k <= 22) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 23) o = '{SRC_T, SRC_E10, DST_E20};
        else if (k == 24) o = '{SRC_E20, SRC_E20, DST_T};
        else if (k <= 43) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 44) o = '{SRC_T, SRC_E20, DST_T};
        else if (k <= 54) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 55) o = '{SRC_T, SRC_E10, DST_E50};
        else if (k == 56) o = '{SRC_E50, SRC_E50, DST_T};
        else if (k <= 105) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 106) o = '{SRC_T, SRC_E50, DST_E100};
        else if (k == 107) o = '{SRC_E100, SRC_E100, DST_T};
        else if (k <= 206) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 207) o = '{SRC_T, SRC_E100, DST_T};
        else if (k <= 257) o = '{SRC_T, SRC_T, DST_T};
        else if (k == 258) o = '{SRC_T, SRC_E50, DST_T};
        else if (k <= 263) o = '{SRC_T, SRC_T, DST_T};
        else o = '{SRC_T, SRC_Z11, DST_T};
        return o;
    endfunction
endpackage

>>> hw/rtl/field_invert_mod_p25519_core.sv
// Inverts one element of GF(2^255-19) given as ten 27-bit limbs in 26/25-bit
// radix. Pulse i_start with valid limbs while o_busy is low; o_busy rises and
// after 265 field multiplications the result appears on o_out_limb0..9 with
// o_done high for one cycle. The result is not buffered: capture it in the
// cycle o_done is high. Each multiplication runs one limb of f against all
// ten limbs of g per cycle on a shared row of ten multipliers, then carry
// propagation in states ST_CA and ST_CB.
module field_invert_mod_p25519_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [26:0] i_in_limb0,
    input  logic [26:0] i_in_limb1,
    input  logic [26:0] i_in_limb2,
    input  logic [26:0] i_in_limb3,
    input  logic [26:0] i_in_limb4,
    input  logic [26:0] i_in_limb5,
    input  logic [26:0] i_in_limb6,
    input  logic [26:0] i_in_limb7,
    input  logic [26:0] i_in_limb8,
    input  logic [26:0] i_in_limb9,
    output logic        o_done,
    output logic [26:0] o_out_limb0,
    output logic [26:0] o_out_limb1,
    output logic [26:0] o_out_limb2,
    output logic [26:0] o_out_limb3,
    output logic [26:0] o_out_limb4,
    output logic [26:0] o_out_limb5,
    output logic [26:0] o_out_limb6,
    output logic [26:0] o_out_limb7,
    output logic [26:0] o_out_limb8,
    output logic [26:0] o_out_limb9
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CA   = 2'd2;
    localparam logic [1:0] ST_CB   = 2'd3;

    logic [1:0] r_st, n_st;
    logic [fimp_pkg::OpW-1:0] r_op, n_op;
    logic [3:0] r_row, n_row;
    logic r_done, n_done;
    fimp_pkg::t_fe r_reg [0:9];
    logic [63:0] r_acc [0:9];
    fimp_pkg::t_fe f, g;
    fimp_pkg::t_op op;
    logic [63:0] prod [0:9];
    logic [63:0] ca [0:9];
    logic [63:0] cb [0:9];
    logic [26:0] fi;
    logic [63:0] c;

    assign op = fimp_pkg::op_of(r_op);
    assign f = r_reg[op.a];
    assign g = r_reg[op.b];
    assign fi = f[r_row];

    always_comb begin
        for (int j = 0; j < 10; j++) begin
            logic [4:0] k;
            logic [31:0] a;
            logic [31:0] b;
            k = 5'(r_row) + 5'(j);
            a = ((r_row[0]) && (j % 2 == 1)) ? {4'd0, fi, 1'b0} : {5'd0, fi};
            b = (k >= 5'd10) ? 32'(g[j]) * 32'd19 : 32'(g[j]);
            prod[j] = 64'(a) * 64'(b);
        end
    end

    // first part of the carry: rounds one through four of both chains
    always_comb begin
        for (int i = 0; i < 10; i++) ca[i] = r_acc[i];
        c = ca[0] >> 26; ca[0] &= 64'h3FFFFFF; ca[1] += c;
        c = ca[5] >> 25; ca[5] &= 64'h1FFFFFF; ca[6] += c;
        c = ca[1] >> 25; ca[1] &= 64'h1FFFFFF; ca[2] += c;
        c = ca[6] >> 26; ca[6] &= 64'h3FFFFFF; ca[7] += c;
        c = ca[2] >> 26; ca[2] &= 64'h3FFFFFF; ca[3] += c;
        c = ca[7] >> 25; ca[7] &= 64'h1FFFFFF; ca[8] += c;
        c = ca[3] >> 25; ca[3] &= 64'h1FFFFFF; ca[4] += c;
        c = ca[8] >> 26; ca[8] &= 64'h3FFFFFF; ca[9] += c;
    end

    always_comb begin
        logic [63:0] d;
        for (int i = 0; i < 10; i++) cb[i] = r_acc[i];
        d = cb[4] >> 26; cb[4] &= 64'h3FFFFFF; cb[5] += d;
        d = cb[9] >> 25; cb[9] &= 64'h1FFFFFF; cb[0] += d * 64'd19;
        d = cb[5] >> 25; cb[5] &= 64'h1FFFFFF; cb[6] += d;
        d = cb[0] >> 26; cb[0] &= 64'h3FFFFFF; cb[1] += d;
        d = cb[6] >> 26; cb[6] &= 64'h3FFFFFF; cb[7] += d;
        d = cb[1] >> 25; cb[1] &= 64'h1FFFFFF; cb[2] += d;
    end

    always_comb begin
        n_st = r_st;
        n_op = r_op;
        n_row = r_row;
        n_done = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    n_st = ST_MUL;
                    n_op = '0;
                    n_row = '0;
                end
            end
            ST_MUL: begin
                if (r_row == 4'd9) begin
                    n_row = '0;
                    n_st = ST_CA;
                end else begin
                    n_row = r_row + 4'd1;
                end
            end
            ST_CA: n_st = ST_CB;
            ST_CB: begin
                n_row = '0;
                if (r_op == 9'(fimp_pkg::NOps - 1)) begin
                    n_st = ST_IDLE;
                    n_done = 1'b1;
                end else begin
                    n_op = r_op + 9'd1;
                    n_st = ST_MUL;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_op <= '0;
            r_row <= '0;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_op <= n_op;
            r_row <= n_row;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_start) begin
            r_reg[1] <= {i_in_limb9, i_in_limb8, i_in_limb7, i_in_limb6, i_in_limb5,
                         i_in_limb4, i_in_limb3, i_in_limb2, i_in_limb1, i_in_limb0};
        end
        if (r_st == ST_MUL) begin
            for (int j = 0; j < 10; j++) begin
                logic [3:0] k;
                k = (5'(r_row) + 5'(j) >= 5'd10) ? 4'(5'(r_row) + 5'(j) - 5'd10)
                                                 : 4'(5'(r_row) + 5'(j));
                if (r_row == 4'd0) r_acc[k] <= prod[j];
                else r_acc[k] <= r_acc[k] + prod[j];
            end
        end
        if (r_st == ST_CA) begin
            for (int i = 0; i < 10; i++) r_acc[i] <= ca[i];
        end
        if (r_st == ST_CB) begin
            for (int i = 0; i < 10; i++) r_reg[op.d][i] <= cb[i][26:0];
        end
    end

    assign o_busy = (r_st != ST_IDLE);
    assign o_done = r_done;
    assign o_out_limb0 = r_reg[0][0];
    assign o_out_limb1 = r_reg[0][1];
    assign o_out_limb2 = r_reg[0][2];
    assign o_out_limb3 = r_reg[0][3];
    assign o_out_limb4 = r_reg[0][4];
    assign o_out_limb5 = r_reg[0][5];
    assign o_out_limb6 = r_reg[0][6];
    assign o_out_limb7 = r_reg[0][7];
    assign o_out_limb8 = r_reg[0][8];
    assign o_out_limb9 = r_reg[0][9];
endmodule

>>> hw/rtl/fimp_checker.sv
`include "field_invert_mod_p25519_core_macros.svh"
module fimp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);
    `FIMP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `FIMP_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `FIMP_ASSERT_NEXT(a_done_once, i_clk, i_rst_n, o_done, !o_done)
    `FIMP_ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, o_done, $past(o_busy))
endmodule

bind field_invert_mod_p25519_core fimp_checker u_fimp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done)
);

>>> verif/field_invert_mod_p25519_core_checker.sv
`timescale 1ns / 1ps

module field_invert_mod_p25519_core_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  fimp_pkg::t_fe i_operand,
    input  logic          i_done,
    input  fimp_pkg::t_fe i_inverse,
    output int            o_pending,
    output int            o_errors
);
    typedef logic [fimp_pkg::NLimb-1:0][63:0] t_acc;

    localparam int CarryOrder [14] = '{0, 5, 1, 6, 2, 7, 3, 8, 4, 9, 5, 0, 6, 1};

    fimp_pkg::t_fe inverse_q [$];

    function automatic t_acc field_mul(input t_acc f, input t_acc g);
        t_acc acc;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        int k;
        int s;
        int w;
        acc = '0;
        for (int i = 0; i < fimp_pkg::NLimb; i++) begin
            for (int j = 0; j < fimp_pkg::NLimb; j++) begin
                a = f[i];
                b = g[j];
                k = i + j;
                if ((i % 2 == 1) && (j % 2 == 1)) a = a * 2;
                if (k >= fimp_pkg::NLimb) begin
                    b = b * 19;
                    k = k - fimp_pkg::NLimb;
                end
                acc[k] = acc[k] + a * b;
            end
        end
        for (int n = 0; n < 14; n++) begin
            s = CarryOrder[n];
            w = (s % 2 == 0) ? 26 : 25;
            c = acc[s] >> w;
            acc[s] = acc[s] & ((64'd1 << w) - 1);
            if (s == fimp_pkg::NLimb - 1) acc[0] = acc[0] + c * 19;
            else acc[s+1] = acc[s+1] + c;
        end
        return acc;
    endfunction

    function automatic t_acc square_n(input t_acc f, input int n);
        t_acc h;
        h = f;
        for (int i = 0; i < n; i++) h = field_mul(h, h);
        return h;
    endfunction

    function automatic fimp_pkg::t_fe field_inverse(input fimp_pkg::t_fe z_in);
        t_acc z, z2, z9, z11, e5, e10, e20, e50, e100, t;
        fimp_pkg::t_fe r;
        for (int i = 0; i < fimp_pkg::NLimb; i++) z[i] = 64'(z_in[i]);
        z2   = field_mul(z, z);
        t    = square_n(z2, 2);
        z9   = field_mul(t, z);
        z11  = field_mul(z9, z2);
        t    = field_mul(z11, z11);
        e5   = field_mul(t, z9);
        t    = square_n(e5, 5);
        e10  = field_mul(t, e5);
        t    = square_n(e10, 10);
        e20  = field_mul(t, e10);
        t    = square_n(e20, 20);
        t    = field_mul(t, e20);
        t    = square_n(t, 10);
        e50  = field_mul(t, e10);
        t    = square_n(e50, 50);
        e100 = field_mul(t, e50);
        t    = square_n(e100, 100);
        t    = field_mul(t, e100);
        t    = square_n(t, 50);
        t    = field_mul(t, e50);
        t    = square_n(t, 5);
        t    = field_mul(t, z11);
        for (int i = 0; i < fimp_pkg::NLimb; i++) r[i] = t[i][fimp_pkg::LimbW-1:0];
        return r;
    endfunction

    assign o_pending = inverse_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        fimp_pkg::t_fe want;
        int bad;
        bad = 0;
        if (i_rst_n) begin
            if (i_start && !i_busy) inverse_q.push_back(field_inverse(i_operand));
            if (i_done) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected word, got %h", $time, i_inverse);
                    bad = 1;
                end else begin
                    want = inverse_q.pop_front();
                    for (int i = 0; i < fimp_pkg::NLimb; i++) begin
                        if (i_inverse[i] !== want[i]) begin
                            $display("%0t: limb %0d expected %h actual %h",
                                     $time, i, want[i], i_inverse[i]);
                            bad = bad + 1;
                        end
                    end
                end
            end
            if (bad != 0) o_errors <= o_errors + bad;
        end
    end
endmodule

>>> verif/field_invert_mod_p25519_core_tb.sv
`timescale 1ns / 1ps

module field_invert_mod_p25519_core_tb;
    localparam int MaxCycles = 4000000;
    localparam logic [26:0] Mask26 = 27'h3FFFFFF;
    localparam logic [26:0] Mask25 = 27'h1FFFFFF;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_start;
    logic          o_busy;
    logic          o_done;
    fimp_pkg::t_fe operand;
    fimp_pkg::t_fe inverse;
    int            pending;
    int            errors;
    int            cycles;

    field_invert_mod_p25519_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in_limb0(operand[0]), .i_in_limb1(operand[1]), .i_in_limb2(operand[2]),
        .i_in_limb3(operand[3]), .i_in_limb4(operand[4]), .i_in_limb5(operand[5]),
        .i_in_limb6(operand[6]), .i_in_limb7(operand[7]), .i_in_limb8(operand[8]),
        .i_in_limb9(operand[9]),
        .o_done(o_done),
        .o_out_limb0(inverse[0]), .o_out_limb1(inverse[1]), .o_out_limb2(inverse[2]),
        .o_out_limb3(inverse[3]), .o_out_limb4(inverse[4]), .o_out_limb5(inverse[5]),
        .o_out_limb6(inverse[6]), .o_out_limb7(inverse[7]), .o_out_limb8(inverse[8]),
        .o_out_limb9(inverse[9])
    );

    field_invert_mod_p25519_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_operand(operand), .i_done(o_done), .i_inverse(inverse),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MaxCycles) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input fimp_pkg::t_fe word);
        i_start <= 1'b1;
        operand <= word;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic fimp_pkg::t_fe field_prime(input logic [26:0] low_add);
        fimp_pkg::t_fe w;
        for (int i = 0; i < fimp_pkg::NLimb; i++) w[i] = (i % 2 == 0) ? Mask26 : Mask25;
        w[0] = Mask26 - 27'd18 + low_add;
        return w;
    endfunction

    function automatic fimp_pkg::t_fe random_word();
        fimp_pkg::t_fe w;
        int shape;
        shape = $urandom_range(0, 3);
        for (int i = 0; i < fimp_pkg::NLimb; i++) begin
            case (shape)
                0: w[i] = 27'($urandom);
                1: w[i] = 27'($urandom) & ((i % 2 == 0) ? Mask26 : Mask25);
                2: w[i] = ($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'd0;
                default: w[i] = $urandom_range(0, 1) ? 27'h4000000 : 27'($urandom);
            endcase
        end
        return w;
    endfunction

    initial begin
        fimp_pkg::t_fe word;
        int burst;
        cycles = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        operand <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word('0);
        send_word({fimp_pkg::NLimb{27'h7FFFFFF}});
        send_word({fimp_pkg::NLimb{27'h4000000}});
        word = '0;
        word[0] = 27'd1;
        send_word(word);
        pause(3);
        send_word(field_prime(27'd0));
        send_word(field_prime(27'd1));
        send_word(field_prime(27'd2));
        word = '0;
        word[0] = 27'd2;
        send_word(word);
        send_word({fimp_pkg::NLimb{27'h5555555}});
        send_word({fimp_pkg::NLimb{27'h2AAAAAA}});
        for (int i = 0; i < fimp_pkg::NLimb; i++) begin
            word = '0;
            word[i] = 27'h7FFFFFF;
            send_word(word);
        end
        pause(1);
        wait (pending == 0);
        @(posedge i_clk);

        for (int n = 0; n < 200; ) begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst && n < 200; b++, n++) send_word(random_word());
            if ($urandom_range(0, 9) == 0) begin
                pause(1);
                wait (pending == 0);
                @(posedge i_clk);
            end else begin
                pause($urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(3000, 3300));
            end
        end
        pause(1);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
